### hw/rtl/msec_pkg.sv
`default_nettype none

package msec_pkg;

    // Data memory geometry: four byte lanes, one word row per lane entry.
    localparam int DMEM_BYTES = 65536;
    localparam int DMEM_AW    = $clog2(DMEM_BYTES);
    localparam int BANK_ROWS  = DMEM_BYTES / 4;
    localparam int ROW_AW     = DMEM_AW - 2;

    localparam int NREGS = 32;
    localparam int RF_AW = $clog2(NREGS);

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    // Item kinds
    localparam logic FUNC_EXEC    = 1'b0;
    localparam logic FUNC_PRELOAD = 1'b1;

    // Opcodes
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // R-type functions
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_NOR  = 6'd39;

    // Register writeback of one instruction
    typedef struct packed {
        logic               en;
        logic               load;
        logic [RF_AW-1:0]   idx;
        logic [31:0]        value;
    } t_wb;

    // Data memory access: word store, byte preload, or read address only
    typedef struct packed {
        logic               wr_word;
        logic               wr_byte;
        logic [DMEM_AW-1:0] addr;
        logic [31:0]        data;
    } t_dmem_req;

endpackage

`default_nettype wire

### hw/rtl/msec_ram.sv
`default_nettype none

module msec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/msec_regfile.sv
`default_nettype none

module msec_regfile (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [msec_pkg::RF_AW-1:0] i_raddr_a,
    input  wire logic [msec_pkg::RF_AW-1:0] i_raddr_b,
    input  wire logic                      i_we,
    input  wire logic [msec_pkg::RF_AW-1:0] i_waddr,
    input  wire logic [31:0]               i_wdata,
    output logic      [31:0]               o_rdata_a,
    output logic      [31:0]               o_rdata_b
);
    import msec_pkg::*;

    logic [NREGS-1:0] r_valid;
    logic             r_va;
    logic             r_vb;
    logic             r_byp_a;
    logic             r_byp_b;
    logic [31:0]      r_byp_data;
    logic [31:0]      ram_a;
    logic [31:0]      ram_b;

    // two copies, one per read port
    msec_ram #(.WIDTH(32), .DEPTH(NREGS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr_a),
        .o_rdata (ram_a)
    );

    msec_ram #(.WIDTH(32), .DEPTH(NREGS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr_b),
        .o_rdata (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_byp_a <= 1'b0;
            r_byp_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_va    <= r_valid[i_raddr_a];
            r_vb    <= r_valid[i_raddr_b];
            // same-edge write is not seen by the RAM read
            r_byp_a <= i_we && (i_waddr == i_raddr_a);
            r_byp_b <= i_we && (i_waddr == i_raddr_b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_wdata;
    end

    assign o_rdata_a = r_byp_a ? r_byp_data : (r_va ? ram_a : 32'd0);
    assign o_rdata_b = r_byp_b ? r_byp_data : (r_vb ? ram_b : 32'd0);

endmodule

`default_nettype wire

### hw/rtl/msec_dmem.sv
`default_nettype none

module msec_dmem (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire msec_pkg::t_dmem_req i_req,
    output logic                     o_busy,
    output logic      [31:0]         o_rd_word
);
    import msec_pkg::*;

    logic              r_clearing;
    logic [ROW_AW-1:0] r_clr_row;
    logic [1:0]        r_base;

    logic [1:0]         pos      [4];
    logic [DMEM_AW-1:0] lane_sum [4];
    logic [31:0]        wshift   [4];
    logic [7:0]         lane_rd  [4];

    // Lane k holds bytes whose address is k mod 4. A word at byte address A
    // touches each lane once; pos is the big-endian byte position in the word.
    for (genvar k = 0; k < 4; k++) begin : g_lane
        localparam logic [1:0] LANE = 2'(k);
        logic              we;
        logic [ROW_AW-1:0] row;
        logic [7:0]        wbyte;

        assign pos[k]      = LANE - i_req.addr[1:0];
        assign lane_sum[k] = i_req.addr + DMEM_AW'(pos[k]);
        assign wshift[k]   = i_req.data << {pos[k], 3'b000};
        assign row         = lane_sum[k][DMEM_AW-1:2];
        assign wbyte       = i_req.wr_byte ? i_req.data[7:0] : wshift[k][31:24];
        assign we          = r_clearing || i_req.wr_word
                             || (i_req.wr_byte && (i_req.addr[1:0] == LANE));

        msec_ram #(.WIDTH(8), .DEPTH(BANK_ROWS)) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (r_clearing ? r_clr_row : row),
            .i_wdata (r_clearing ? 8'd0 : wbyte),
            .i_raddr (row),
            .o_rdata (lane_rd[k])
        );
    end

    // zero sweep after reset, one row of all four lanes per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_AW'(BANK_ROWS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= i_req.addr[1:0];
    end

    always_comb begin
        o_rd_word = '0;
        for (int p = 0; p < 4; p++) begin
            o_rd_word[8*(3-p) +: 8] = lane_rd[2'(r_base + 2'(p))];
        end
    end

    assign o_busy = r_clearing;

endmodule

`default_nettype wire

### hw/rtl/msec_exec.sv
`default_nettype none

module msec_exec (
    input  wire logic                        i_func,
    input  wire logic [31:0]                 i_ins,
    input  wire logic [15:0]                 i_load_address,
    input  wire logic [7:0]                  i_load_byte,
    input  wire logic [31:0]                 i_pc,
    input  wire logic                        i_halt,
    input  wire logic [31:0]                 i_a,
    input  wire logic [31:0]                 i_b,
    output logic      [31:0]                 o_next_pc,
    output logic                             o_halt,
    output logic                             o_illegal,
    output msec_pkg::t_wb                    o_wb,
    output logic                             o_mem_we,
    output logic      [msec_pkg::DMEM_AW-1:0] o_mem_addr,
    output logic      [31:0]                 o_mem_wval,
    output msec_pkg::t_dmem_req              o_req
);
    import msec_pkg::*;

    logic [5:0]       op;
    logic [5:0]       fn;
    logic [RF_AW-1:0] rt;
    logic [RF_AW-1:0] rd;
    logic [31:0]      imm;
    logic [31:0]      pc4;
    logic [31:0]      ea;
    logic             wr;
    logic             ld;
    logic [RF_AW-1:0] widx;
    logic [31:0]      wval;

    assign op  = i_ins[31:26];
    assign fn  = i_ins[5:0];
    assign rt  = i_ins[20:16];
    assign rd  = i_ins[15:11];
    assign imm = {{16{i_ins[15]}}, i_ins[15:0]};
    assign pc4 = i_pc + 32'd4;
    assign ea  = i_a + imm;

    always_comb begin
        o_next_pc  = i_pc;
        o_halt     = i_halt;
        o_illegal  = 1'b0;
        o_mem_we   = 1'b0;
        o_mem_addr = '0;
        o_mem_wval = '0;
        o_req      = '0;
        wr         = 1'b0;
        ld         = 1'b0;
        widx       = '0;
        wval       = '0;

        if (i_func == FUNC_PRELOAD) begin
            o_req.wr_byte = 1'b1;
            o_req.addr    = i_load_address[DMEM_AW-1:0];
            o_req.data    = {24'd0, i_load_byte};
        end else if (!i_halt) begin
            if (i_ins == HALT_WORD) begin
                o_halt = 1'b1;
            end else begin
                case (op)
                    OP_RTYPE: begin
                        o_next_pc = pc4;
                        widx      = rd;
                        wr        = 1'b1;
                        case (fn)
                            FN_ADDU: wval = i_a + i_b;
                            FN_SUBU: wval = i_a - i_b;
                            FN_AND:  wval = i_a & i_b;
                            FN_OR:   wval = i_a | i_b;
                            FN_NOR:  wval = ~(i_a | i_b);
                            default: wr   = 1'b0;
                        endcase
                    end
                    OP_ADDIU: begin
                        o_next_pc = pc4;
                        wr        = 1'b1;
                        widx      = rt;
                        wval      = ea;
                    end
                    OP_BEQ: begin
                        o_next_pc = (i_a == i_b) ? pc4 + {imm[29:0], 2'b00} : pc4;
                    end
                    OP_LW: begin
                        o_next_pc  = pc4;
                        o_mem_addr = ea[DMEM_AW-1:0];
                        o_req.addr = ea[DMEM_AW-1:0];
                        wr         = 1'b1;
                        ld         = 1'b1;
                        widx       = rt;
                    end
                    OP_SW: begin
                        o_next_pc     = pc4;
                        o_mem_addr    = ea[DMEM_AW-1:0];
                        o_mem_we      = 1'b1;
                        o_mem_wval    = i_b;
                        o_req.wr_word = 1'b1;
                        o_req.addr    = ea[DMEM_AW-1:0];
                        o_req.data    = i_b;
                    end
                    OP_J: begin
                        o_next_pc = {pc4[31:28], i_ins[25:0], 2'b00};
                    end
                    default: begin
                        o_illegal = 1'b1;
                        o_halt    = 1'b1;
                    end
                endcase
            end
        end

        // $0 writes are dropped entirely
        o_wb = '0;
        if (wr && (widx != '0)) begin
            o_wb.en    = 1'b1;
            o_wb.load  = ld;
            o_wb.idx   = widx;
            o_wb.value = wval;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mips_subset_execute_core_unit.sv
// Channel  | Direction | Handshake               | Beat payload
// ---------+-----------+-------------------------+---------------------------------------------
// in       | into core | i_in_valid / o_in_stall | i_func, i_instruction, i_load_address,
//          |           |                         | i_load_byte
// out      | from core | o_out_valid/i_out_stall | o_next_pc, o_halted, o_illegal_opcode,
//          |           |                         | o_reg_write_*, o_mem_write_*, o_mem_address
//
// Two stages, input register (execute) then output register (writeback), set
// by the synchronous register-file and data-memory reads. One beat per cycle
// is sustained while the output channel is not stalled.
// After reset the data memory is swept to zero, all 16384 rows, with o_in_stall high.
// An output stall holds the output register; a full input register raises
// o_in_stall in the same cycle, an empty one takes one more beat first.
`default_nettype none

module mips_subset_execute_core_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_instruction,
    input  wire logic [15:0] i_load_address,
    input  wire logic [7:0]  i_load_byte,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_next_pc,
    output logic             o_halted,
    output logic             o_illegal_opcode,
    output logic             o_reg_write_enable,
    output logic      [4:0]  o_reg_write_index,
    output logic      [31:0] o_reg_write_value,
    output logic             o_mem_write_enable,
    output logic      [15:0] o_mem_address,
    output logic      [31:0] o_mem_write_value
);
    import msec_pkg::*;

    // architectural state
    logic [31:0] r_pc;
    logic        r_halt;

    // execute stage (input register)
    logic        r_s1_valid;
    logic        r_s1_func;
    logic [31:0] r_s1_ins;
    logic [15:0] r_s1_laddr;
    logic [7:0]  r_s1_lbyte;

    // writeback stage (output register)
    logic               r_s2_valid;
    logic [31:0]        r_s2_next_pc;
    logic               r_s2_halted;
    logic               r_s2_illegal;
    t_wb                r_s2_wb;
    logic               r_s2_mwe;
    logic [DMEM_AW-1:0] r_s2_maddr;
    logic [31:0]        r_s2_mval;

    // handshake
    logic s2_free;
    logic s2_adv;
    logic s1_free;
    logic s1_adv;
    logic in_acc;

    // execute results
    logic [31:0]        n_pc;
    logic               n_halt;
    logic               ex_illegal;
    t_wb                ex_wb;
    logic               ex_mwe;
    logic [DMEM_AW-1:0] ex_maddr;
    logic [31:0]        ex_mval;
    t_dmem_req          ex_req;
    t_dmem_req          mem_req;

    logic [RF_AW-1:0] rs_addr;
    logic [RF_AW-1:0] rt_addr;
    logic [31:0]      rf_a;
    logic [31:0]      rf_b;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic [31:0]      wb_value;
    logic [31:0]      dmem_word;
    logic             dmem_busy;

    assign s2_free    = !r_s2_valid || !i_out_stall;
    assign s2_adv     = r_s2_valid && !i_out_stall;
    assign s1_free    = !r_s1_valid || s2_free;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_stall = dmem_busy || !s1_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Register reads are launched as the beat enters the input register and
    // repeated from the held instruction while it waits.
    assign rs_addr = in_acc ? i_instruction[25:21] : r_s1_ins[25:21];
    assign rt_addr = in_acc ? i_instruction[20:16] : r_s1_ins[20:16];

    msec_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (rs_addr),
        .i_raddr_b (rt_addr),
        .i_we      (s2_adv && r_s2_wb.en),
        .i_waddr   (r_s2_wb.idx),
        .i_wdata   (wb_value),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    // The writeback stage holds the only unwritten register result; forward it.
    // Load data comes straight from the data memory read register.
    assign wb_value = r_s2_wb.load ? dmem_word : r_s2_wb.value;
    assign op_a = (r_s2_valid && r_s2_wb.en && (r_s2_wb.idx == r_s1_ins[25:21]))
                  ? wb_value : rf_a;
    assign op_b = (r_s2_valid && r_s2_wb.en && (r_s2_wb.idx == r_s1_ins[20:16]))
                  ? wb_value : rf_b;

    msec_exec u_exec (
        .i_func         (r_s1_func),
        .i_ins          (r_s1_ins),
        .i_load_address (r_s1_laddr),
        .i_load_byte    (r_s1_lbyte),
        .i_pc           (r_pc),
        .i_halt         (r_halt),
        .i_a            (op_a),
        .i_b            (op_b),
        .o_next_pc      (n_pc),
        .o_halt         (n_halt),
        .o_illegal      (ex_illegal),
        .o_wb           (ex_wb),
        .o_mem_we       (ex_mwe),
        .o_mem_addr     (ex_maddr),
        .o_mem_wval     (ex_mval),
        .o_req          (ex_req)
    );

    // Writes only when the execute stage moves on. While the writeback stage
    // waits, the read address stays on its load so the read data holds.
    always_comb begin
        mem_req         = ex_req;
        mem_req.wr_word = s1_adv && ex_req.wr_word;
        mem_req.wr_byte = s1_adv && ex_req.wr_byte;
        if (!s1_adv) begin
            mem_req.addr = r_s2_maddr;
        end
    end

    msec_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_busy    (dmem_busy),
        .o_rd_word (dmem_word)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_halt     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
            end
            if (s1_free) begin
                r_s1_valid <= in_acc;
            end
            if (s2_free) begin
                r_s2_valid <= s1_adv;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func  <= i_func;
            r_s1_ins   <= i_instruction;
            r_s1_laddr <= i_load_address;
            r_s1_lbyte <= i_load_byte;
        end
        if (s1_adv) begin
            r_s2_next_pc <= n_pc;
            r_s2_halted  <= n_halt;
            r_s2_illegal <= ex_illegal;
            r_s2_wb      <= ex_wb;
            r_s2_mwe     <= ex_mwe;
            r_s2_maddr   <= ex_maddr;
            r_s2_mval    <= ex_mval;
        end
    end

    assign o_out_valid        = r_s2_valid;
    assign o_next_pc          = r_s2_next_pc;
    assign o_halted           = r_s2_halted;
    assign o_illegal_opcode   = r_s2_illegal;
    assign o_reg_write_enable = r_s2_wb.en;
    assign o_reg_write_index  = r_s2_wb.idx;
    assign o_reg_write_value  = r_s2_wb.en ? wb_value : 32'd0;
    assign o_mem_write_enable = r_s2_mwe;
    assign o_mem_address      = 16'(r_s2_maddr);
    assign o_mem_write_value  = r_s2_mval;

    // Once halted, only reset brings the core back; the PC freezes.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> (r_halt && $stable(r_pc)))
        else $error("halt flag dropped or PC moved while halted");

    a_illegal_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_illegal_opcode) |-> o_halted)
        else $error("illegal opcode without halt");

    a_no_reg0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reg_write_enable) |-> (o_reg_write_index != 5'd0))
        else $error("write to register zero reported");

    a_one_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_reg_write_enable && o_mem_write_enable))
        else $error("register and memory write in one beat");

    a_no_exec_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dmem_busy |-> (!r_s1_valid && !r_s2_valid))
        else $error("beat in flight during memory sweep");

endmodule

`default_nettype wire
